/* rtl/hba_pkg.sv */
`default_nettype none

package hba_pkg;

    // fixed field widths
    localparam int unsigned SPAN_W     = 32;
    localparam int unsigned STATUS_W   = 3;

    // page geometry
    localparam int unsigned PAGE_SHIFT = 12;
    localparam int unsigned PAGE_BYTES = 1 << PAGE_SHIFT;
    localparam int unsigned PAGE_W     = SPAN_W - PAGE_SHIFT;

    // break alignment
    localparam int unsigned ALIGN_SHIFT = 3;
    localparam int unsigned ALIGN_BYTES = 1 << ALIGN_SHIFT;

    // metadata cost: three 4-byte words per heap page
    localparam int unsigned META_BYTES_PER_PAGE = 3 * 4;
    localparam int unsigned MB_W   = PAGE_W + 4;
    localparam int unsigned META_W = MB_W + 1 - PAGE_SHIFT;

    // layout solver bound
    localparam int unsigned MAX_SOLVE_STEPS = 16;
    localparam int unsigned STEP_W          = $clog2(MAX_SOLVE_STEPS);

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_READY = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_ROOM   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DENIED    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd4;

    // command codes
    localparam logic CMD_INIT   = 1'b0;
    localparam logic CMD_ADJUST = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic                load;
        logic                solve_step;
        logic                commit;
        logic                adj_apply;
        logic                emit;
        logic                emit_shrink;
        logic [STATUS_W-1:0] emit_status;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic                started;
        logic                solve_fail;
        logic                solve_settled;
        logic                heap_zero;
        logic                adj_neg;
        logic [STATUS_W-1:0] adj_code;
    } t_dp_stat;

endpackage

`default_nettype wire

/* rtl/hba_ctrl.sv */
`default_nettype none

module hba_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_cmd,
    input  wire logic              i_reserve_ok,
    input  wire hba_pkg::t_dp_stat i_stat,
    output hba_pkg::t_dp_cmd       o_cmd,
    output logic                   o_busy
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SOLVE  = 2'd1;
    localparam logic [1:0] S_ADJ    = 2'd2;
    localparam logic [1:0] S_SHRINK = 2'd3;

    localparam logic [hba_pkg::STEP_W-1:0] LAST_STEP =
        hba_pkg::STEP_W'(hba_pkg::MAX_SOLVE_STEPS - 1);

    logic [1:0]                 r_state, n_state;
    logic [hba_pkg::STEP_W-1:0] r_step,  n_step;

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_cmd == hba_pkg::CMD_INIT) begin
                        if (i_stat.started) begin
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_status = hba_pkg::ST_OK;
                        end else if (!i_reserve_ok) begin
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_status = hba_pkg::ST_NOT_READY;
                        end else begin
                            o_cmd.load = 1'b1;
                            n_step     = '0;
                            n_state    = S_SOLVE;
                        end
                    end else begin
                        if (!i_stat.started) begin
                            o_cmd.emit        = 1'b1;
                            o_cmd.emit_status = hba_pkg::ST_NOT_READY;
                        end else begin
                            o_cmd.load = 1'b1;
                            n_state    = S_ADJ;
                        end
                    end
                end
            end
            S_SOLVE: begin
                if (i_stat.solve_fail) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_status = hba_pkg::ST_NOT_READY;
                    n_state           = S_IDLE;
                end else if (i_stat.solve_settled) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.heap_zero) begin
                        o_cmd.emit_status = hba_pkg::ST_NOT_READY;
                    end else begin
                        o_cmd.commit      = 1'b1;
                        o_cmd.emit_status = hba_pkg::ST_OK;
                    end
                    n_state = S_IDLE;
                end else if (r_step == LAST_STEP) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_status = hba_pkg::ST_NOT_READY;
                    n_state           = S_IDLE;
                end else begin
                    o_cmd.solve_step = 1'b1;
                    n_step           = r_step + 1'b1;
                end
            end
            S_ADJ: begin
                if (i_stat.adj_code != hba_pkg::ST_OK) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_status = i_stat.adj_code;
                    n_state           = S_IDLE;
                end else if (i_stat.adj_neg) begin
                    o_cmd.adj_apply = 1'b1;
                    n_state         = S_SHRINK;
                end else begin
                    o_cmd.adj_apply   = 1'b1;
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_status = hba_pkg::ST_OK;
                    n_state           = S_IDLE;
                end
            end
            S_SHRINK: begin
                o_cmd.emit        = 1'b1;
                o_cmd.emit_shrink = 1'b1;
                o_cmd.emit_status = hba_pkg::ST_OK;
                n_state           = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

/* rtl/hba_datapath.sv */
`default_nettype none

module hba_datapath (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire hba_pkg::t_dp_cmd                    i_cmd,
    output hba_pkg::t_dp_stat                        o_stat,
    input  wire logic                                i_cfg_write,
    input  wire logic                                i_cfg_data,
    input  wire logic [hba_pkg::SPAN_W-1:0]          i_region_span,
    input  wire logic signed [hba_pkg::SPAN_W-1:0]   i_increment,
    input  wire logic                                i_policy_allows,
    output logic                                     o_valid,
    output logic [hba_pkg::STATUS_W-1:0]             o_status,
    output logic [hba_pkg::SPAN_W-1:0]               o_break_offset,
    output logic                                     o_decommit_valid,
    output logic [hba_pkg::SPAN_W-1:0]               o_decommit_start,
    output logic [hba_pkg::SPAN_W-1:0]               o_decommit_length,
    output logic [hba_pkg::PAGE_W-1:0]               o_heap_page_count,
    output logic [hba_pkg::PAGE_W-1:0]               o_metadata_page_count
);

    localparam int unsigned SW = hba_pkg::SPAN_W;
    localparam int unsigned PW = hba_pkg::PAGE_W;
    localparam int unsigned PS = hba_pkg::PAGE_SHIFT;
    localparam int unsigned AS = hba_pkg::ALIGN_SHIFT;
    localparam int unsigned MW = hba_pkg::MB_W;
    localparam int unsigned TW = hba_pkg::META_W;

    // layout state
    logic          r_started;
    logic          r_policy_enabled;
    logic [PW-1:0] r_heap_pg_cnt;
    logic [PW-1:0] r_meta_pages;
    logic [SW-1:0] r_heap_bytes;
    logic [SW-1:0] r_break_used;

    // per-item work registers
    logic [PW-1:0] r_total;
    logic [PW-1:0] r_heap_iter;
    logic          r_neg;
    logic [SW-1:0] r_amount;
    logic [SW-1:0] r_wanted;
    logic [SW-1:0] r_room;
    logic          r_allows;
    logic [SW-1:0] r_old;

    // result registers
    logic                         r_valid;
    logic [hba_pkg::STATUS_W-1:0] r_status;
    logic [SW-1:0]                r_brk_out;
    logic                         r_dvalid;
    logic [SW-1:0]                r_dstart;
    logic [SW-1:0]                r_dlen;
    logic [PW-1:0]                r_heap_out;
    logic [PW-1:0]                r_meta_out;

    logic [SW-1:0] n_amount;
    logic [SW-1:0] n_wanted_sum;
    logic [SW-1:0] n_wanted;
    logic [SW-1:0] n_room;
    logic [MW-1:0] n_mbytes;
    logic [MW:0]   n_mbytes_rnd;
    logic [TW-1:0] n_meta;
    logic [PW-1:0] n_meta_ext;
    logic [PW-1:0] n_next;
    logic [SW-PS:0]  n_ceil_pages;
    logic [SW:0]     n_first;
    logic [SW:0]     n_diff;
    logic            n_dvalid;
    logic [hba_pkg::STATUS_W-1:0] n_adj_code;

    // adjust operands taken at accept
    assign n_amount     = 32'd0 - SW'(i_increment);
    assign n_wanted_sum = SW'(i_increment) + SW'(hba_pkg::ALIGN_BYTES - 1);
    assign n_wanted     = {n_wanted_sum[SW-1:AS], {AS{1'b0}}};
    assign n_room       = (r_heap_bytes >= r_break_used) ?
                          (r_heap_bytes - r_break_used) : '0;

    // one solver pass: metadata pages for the current heap guess
    assign n_mbytes     = MW'(r_heap_iter) * MW'(hba_pkg::META_BYTES_PER_PAGE);
    assign n_mbytes_rnd = {1'b0, n_mbytes} + (MW + 1)'(hba_pkg::PAGE_BYTES - 1);
    assign n_meta       = n_mbytes_rnd[MW:PS];
    assign n_meta_ext   = {{(PW - TW){1'b0}}, n_meta};
    assign n_next       = r_total - n_meta_ext;

    // adjust verdict
    always_comb begin
        if (r_neg) begin
            n_adj_code = (r_amount > r_break_used) ? hba_pkg::ST_UNDERFLOW
                                                   : hba_pkg::ST_OK;
        end else if (r_wanted > r_room) begin
            n_adj_code = hba_pkg::ST_NO_ROOM;
        end else if (r_policy_enabled && !r_allows) begin
            n_adj_code = hba_pkg::ST_DENIED;
        end else begin
            n_adj_code = hba_pkg::ST_OK;
        end
    end

    // released page range above the lowered break
    assign n_ceil_pages = {1'b0, r_break_used[SW-1:PS]} +
                          (SW - PS + 1)'(|r_break_used[PS-1:0]);
    assign n_first      = {n_ceil_pages, {PS{1'b0}}};
    assign n_diff       = {1'b0, r_old} - n_first;
    assign n_dvalid     = !n_diff[SW] && (n_diff[SW-1:0] != '0);

    // status toward the controller
    always_comb begin
        o_stat               = '0;
        o_stat.started       = r_started;
        o_stat.solve_fail    = (n_meta_ext >= r_total);
        o_stat.solve_settled = (n_next == r_heap_iter);
        o_stat.heap_zero     = (r_heap_iter == '0);
        o_stat.adj_neg       = r_neg;
        o_stat.adj_code      = n_adj_code;
    end

    // configuration and layout state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy_enabled <= 1'b0;
            r_started        <= 1'b0;
            r_heap_pg_cnt    <= '0;
            r_meta_pages     <= '0;
            r_heap_bytes     <= '0;
            r_break_used     <= '0;
        end else begin
            if (i_cfg_write) begin
                r_policy_enabled <= i_cfg_data;
            end
            if (i_cmd.commit) begin
                r_started     <= 1'b1;
                r_heap_pg_cnt <= r_heap_iter;
                r_meta_pages  <= n_meta_ext;
                r_heap_bytes  <= {r_heap_iter, {PS{1'b0}}};
                r_break_used  <= '0;
            end else if (i_cmd.adj_apply) begin
                if (r_neg) begin
                    r_break_used <= r_break_used - r_amount;
                end else begin
                    r_break_used <= r_break_used + r_wanted;
                end
            end
        end
    end

    // work registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_total     <= i_region_span[SW-1:PS];
            r_heap_iter <= i_region_span[SW-1:PS];
            r_neg       <= i_increment[SW-1];
            r_amount    <= n_amount;
            r_wanted    <= n_wanted;
            r_room      <= n_room;
            r_allows    <= i_policy_allows;
        end else if (i_cmd.solve_step) begin
            r_heap_iter <= n_next;
        end
        if (i_cmd.adj_apply) begin
            r_old <= r_break_used;
        end
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
    end

    // result beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_status   <= i_cmd.emit_status;
            r_brk_out  <= r_break_used;
            r_heap_out <= i_cmd.commit ? r_heap_iter : r_heap_pg_cnt;
            r_meta_out <= i_cmd.commit ? n_meta_ext  : r_meta_pages;
            if (i_cmd.emit_shrink && n_dvalid) begin
                r_dvalid <= 1'b1;
                r_dstart <= n_first[SW-1:0];
                r_dlen   <= n_diff[SW-1:0];
            end else begin
                r_dvalid <= 1'b0;
                r_dstart <= '0;
                r_dlen   <= '0;
            end
        end
    end

    assign o_valid               = r_valid;
    assign o_status              = r_status;
    assign o_break_offset        = r_brk_out;
    assign o_decommit_valid      = r_dvalid;
    assign o_decommit_start      = r_dstart;
    assign o_decommit_length     = r_dlen;
    assign o_heap_page_count     = r_heap_out;
    assign o_metadata_page_count = r_meta_out;

endmodule

`default_nettype wire

/* rtl/heap_break_allocator_core.sv */
// channel   | ports                                          | handshake
// ----------+------------------------------------------------+--------------------------
// command   | i_cmd, i_region_span, i_reserve_ok,            | start high, busy low
//           | i_increment, i_policy_allows                   |
// result    | o_status, o_break_offset, o_decommit_*,        | o_valid, one cycle
//           | o_heap_page_count, o_metadata_page_count       |
// config    | i_cfg_data                                     | i_cfg_valid, o_cfg_ready
//
// a command that fails or is a repeated init at once gives its beat the cycle after accept
// growth runs operand set-up, then the check; a shrink adds the page round-up after the check
// init runs the layout solver one pass per cycle, at most 16 passes
// busy stays high until the result beat is launched; a new command may start while the beat shows
// synchronous active-low reset clears the layout, the break and the policy bit
// the result beat cannot be held off; o_cfg_ready is always high
`default_nettype none

module heap_break_allocator_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic                                i_cmd,
    input  wire logic [hba_pkg::SPAN_W-1:0]          i_region_span,
    input  wire logic                                i_reserve_ok,
    input  wire logic signed [hba_pkg::SPAN_W-1:0]   i_increment,
    input  wire logic                                i_policy_allows,
    output logic                                     o_valid,
    output logic [hba_pkg::STATUS_W-1:0]             o_status,
    output logic [hba_pkg::SPAN_W-1:0]               o_break_offset,
    output logic                                     o_decommit_valid,
    output logic [hba_pkg::SPAN_W-1:0]               o_decommit_start,
    output logic [hba_pkg::SPAN_W-1:0]               o_decommit_length,
    output logic [hba_pkg::PAGE_W-1:0]               o_heap_page_count,
    output logic [hba_pkg::PAGE_W-1:0]               o_metadata_page_count,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic                                i_cfg_data
);

    hba_pkg::t_dp_cmd  w_cmd;
    hba_pkg::t_dp_stat w_stat;
    logic              w_busy;
    logic              w_start;

    // only accepted beats reach the controller
    assign w_start     = start && !w_busy;
    assign busy        = w_busy;
    assign o_cfg_ready = 1'b1;

    // sequencer
    hba_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_start),
        .i_cmd        (i_cmd),
        .i_reserve_ok (i_reserve_ok),
        .i_stat       (w_stat),
        .o_cmd        (w_cmd),
        .o_busy       (w_busy)
    );

    // layout solver, break arithmetic and result registers
    hba_datapath u_datapath (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (w_cmd),
        .o_stat                (w_stat),
        .i_cfg_write           (i_cfg_valid && o_cfg_ready),
        .i_cfg_data            (i_cfg_data),
        .i_region_span         (i_region_span),
        .i_increment           (i_increment),
        .i_policy_allows       (i_policy_allows),
        .o_valid               (o_valid),
        .o_status              (o_status),
        .o_break_offset        (o_break_offset),
        .o_decommit_valid      (o_decommit_valid),
        .o_decommit_start      (o_decommit_start),
        .o_decommit_length     (o_decommit_length),
        .o_heap_page_count     (o_heap_page_count),
        .o_metadata_page_count (o_metadata_page_count)
    );

endmodule

`default_nettype wire

/* tb/heap_break_checker.sv */
`default_nettype none

module heap_break_checker
    import hba_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    input  wire logic                       busy,
    input  wire logic                       i_cmd,
    input  wire logic [SPAN_W-1:0]          i_region_span,
    input  wire logic                       i_reserve_ok,
    input  wire logic [SPAN_W-1:0]          i_increment,
    input  wire logic                       i_policy_allows,
    input  wire logic                       o_valid,
    input  wire logic [STATUS_W-1:0]        o_status,
    input  wire logic [SPAN_W-1:0]          o_break_offset,
    input  wire logic                       o_decommit_valid,
    input  wire logic [SPAN_W-1:0]          o_decommit_start,
    input  wire logic [SPAN_W-1:0]          o_decommit_length,
    input  wire logic [PAGE_W-1:0]          o_heap_page_count,
    input  wire logic [PAGE_W-1:0]          o_metadata_page_count,
    input  wire logic                       i_cfg_valid,
    input  wire logic                       o_cfg_ready,
    input  wire logic                       i_cfg_data,
    output int                              mismatch_count,
    output int                              results_pending
);

    localparam int PRINT_CAP = 100;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SPAN_W-1:0]   brk;
        logic                dvalid;
        logic [SPAN_W-1:0]   dstart;
        logic [SPAN_W-1:0]   dlen;
        logic [PAGE_W-1:0]   heap_cnt;
        logic [PAGE_W-1:0]   meta_pages;
    } t_break_reply;

    // own copy of the layout, the break and the policy bit
    logic              policy_on;
    logic              layout_set;
    logic [PAGE_W-1:0] heap_pg;
    logic [PAGE_W-1:0] meta_pg;
    logic [SPAN_W-1:0] heap_size;
    logic [SPAN_W-1:0] brk_now;

    t_break_reply predicted_replies[$];

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP) begin
            $display("%0t: %s", $time, msg);
        end
    endtask

    // fixed-point split of the region into heap and metadata pages
    function automatic logic [STATUS_W-1:0] solve_layout(input logic [SPAN_W-1:0] span,
                                                         input logic ok);
        logic [63:0] total;
        logic [63:0] pages;
        logic [63:0] meta;
        logic [63:0] next_pages;
        logic        settled;
        logic        filled;
        total   = 64'(span) >> PAGE_SHIFT;
        pages   = total;
        meta    = '0;
        settled = 1'b0;
        filled  = 1'b0;
        if (layout_set) begin
            return ST_OK;
        end
        if (!ok) begin
            return ST_NOT_READY;
        end
        for (int step = 0; step < MAX_SOLVE_STEPS && !settled && !filled; step++) begin
            meta = (pages * META_BYTES_PER_PAGE + PAGE_BYTES - 1) >> PAGE_SHIFT;
            if (meta >= total) begin
                filled = 1'b1;
            end else begin
                next_pages = total - meta;
                if (next_pages == pages) begin
                    settled = 1'b1;
                end else begin
                    pages = next_pages;
                end
            end
        end
        if (filled || !settled || pages == 0) begin
            return ST_NOT_READY;
        end
        heap_pg    = pages[PAGE_W-1:0];
        meta_pg    = meta[PAGE_W-1:0];
        heap_size  = SPAN_W'(pages << PAGE_SHIFT);
        brk_now    = '0;
        layout_set = 1'b1;
        return ST_OK;
    endfunction

    // expected reply of one command, updating the break as the block should
    function automatic t_break_reply predict_reply(input logic cmd,
                                                   input logic [SPAN_W-1:0] span,
                                                   input logic ok,
                                                   input logic [SPAN_W-1:0] inc,
                                                   input logic allows);
        t_break_reply      r;
        logic [SPAN_W-1:0] amount;
        logic [63:0]       old_brk;
        logic [63:0]       first;
        logic [63:0]       wanted;
        logic [63:0]       room;
        r        = '0;
        r.status = ST_OK;
        if (cmd == CMD_INIT) begin
            r.status = solve_layout(span, ok);
            r.brk    = brk_now;
        end else if (!layout_set) begin
            r.status = ST_NOT_READY;
            r.brk    = brk_now;
        end else if (inc[SPAN_W-1]) begin
            // shrink: release whole pages above the new break
            amount = -inc;
            if (amount > brk_now) begin
                r.status = ST_UNDERFLOW;
            end else begin
                old_brk = 64'(brk_now);
                brk_now = brk_now - amount;
                first   = ((64'(brk_now) + PAGE_BYTES - 1) >> PAGE_SHIFT) << PAGE_SHIFT;
                if (first < old_brk) begin
                    r.dvalid = 1'b1;
                    r.dstart = first[SPAN_W-1:0];
                    r.dlen   = SPAN_W'(old_brk - first);
                end
            end
            r.brk = brk_now;
        end else begin
            // growth: room check first, then the policy
            wanted = ((64'(inc) + ALIGN_BYTES - 1) >> ALIGN_SHIFT) << ALIGN_SHIFT;
            room   = (heap_size >= brk_now) ? 64'(heap_size - brk_now) : 64'd0;
            r.brk  = brk_now;
            if (wanted > room) begin
                r.status = ST_NO_ROOM;
            end else if (policy_on && !allows) begin
                r.status = ST_DENIED;
            end else begin
                brk_now = brk_now + wanted[SPAN_W-1:0];
            end
        end
        r.heap_cnt   = heap_pg;
        r.meta_pages = meta_pg;
        return r;
    endfunction

    task automatic check_reply(input t_break_reply exp);
        if (o_status != exp.status) begin
            report_mismatch($sformatf("status got %0d expected %0d", o_status, exp.status));
        end
        if (o_break_offset != exp.brk) begin
            report_mismatch($sformatf("break offset got %0h expected %0h",
                                      o_break_offset, exp.brk));
        end
        if (o_decommit_valid != exp.dvalid) begin
            report_mismatch($sformatf("decommit valid got %0b expected %0b",
                                      o_decommit_valid, exp.dvalid));
        end
        if (o_decommit_start != exp.dstart) begin
            report_mismatch($sformatf("decommit start got %0h expected %0h",
                                      o_decommit_start, exp.dstart));
        end
        if (o_decommit_length != exp.dlen) begin
            report_mismatch($sformatf("decommit length got %0h expected %0h",
                                      o_decommit_length, exp.dlen));
        end
        if (o_heap_page_count != exp.heap_cnt) begin
            report_mismatch($sformatf("heap pages got %0d expected %0d",
                                      o_heap_page_count, exp.heap_cnt));
        end
        if (o_metadata_page_count != exp.meta_pages) begin
            report_mismatch($sformatf("metadata pages got %0d expected %0d",
                                      o_metadata_page_count, exp.meta_pages));
        end
    endtask

    // result beat is checked before a command accepted at the same edge is predicted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            policy_on  = 1'b0;
            layout_set = 1'b0;
            heap_pg    = '0;
            meta_pg    = '0;
            heap_size  = '0;
            brk_now    = '0;
            predicted_replies.delete();
            results_pending <= 0;
        end else begin
            if (o_valid) begin
                if (predicted_replies.size() == 0) begin
                    report_mismatch("result beat with no reply predicted");
                end else begin
                    check_reply(predicted_replies.pop_front());
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                policy_on = i_cfg_data;
            end
            if (start && !busy) begin
                predicted_replies.push_back(predict_reply(i_cmd, i_region_span, i_reserve_ok,
                                                          i_increment, i_policy_allows));
            end
            results_pending <= predicted_replies.size();
        end
    end

endmodule

`default_nettype wire

/* tb/heap_break_allocator_core_test.sv */
`default_nettype none

module heap_break_allocator_core_test;
    import hba_pkg::*;

    localparam int ITEMS       = 1000;
    localparam int PHASES      = 4;
    localparam int EARLY_ITEMS = 40;
    localparam int IDLE_PCT    = 34;
    localparam int STALL_LIMIT = 1000;
    localparam int TAIL_CYCLES = 20;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic                 i_cmd;
    logic [SPAN_W-1:0]    i_region_span;
    logic                 i_reserve_ok;
    logic [SPAN_W-1:0]    i_increment;
    logic                 i_policy_allows;
    logic                 o_valid;
    logic [STATUS_W-1:0]  o_status;
    logic [SPAN_W-1:0]    o_break_offset;
    logic                 o_decommit_valid;
    logic [SPAN_W-1:0]    o_decommit_start;
    logic [SPAN_W-1:0]    o_decommit_length;
    logic [PAGE_W-1:0]    o_heap_page_count;
    logic [PAGE_W-1:0]    o_metadata_page_count;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic                 i_cfg_data;
    int                   mismatch_count;
    int                   results_pending;
    int                   stalled_cycles;
    logic [SPAN_W-1:0]    layout_span;

    always #10 i_clk = ~i_clk;

    heap_break_allocator_core dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .start                 (start),
        .busy                  (busy),
        .i_cmd                 (i_cmd),
        .i_region_span         (i_region_span),
        .i_reserve_ok          (i_reserve_ok),
        .i_increment           (i_increment),
        .i_policy_allows       (i_policy_allows),
        .o_valid               (o_valid),
        .o_status              (o_status),
        .o_break_offset        (o_break_offset),
        .o_decommit_valid      (o_decommit_valid),
        .o_decommit_start      (o_decommit_start),
        .o_decommit_length     (o_decommit_length),
        .o_heap_page_count     (o_heap_page_count),
        .o_metadata_page_count (o_metadata_page_count),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_data            (i_cfg_data)
    );

    heap_break_checker break_check (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .start                 (start),
        .busy                  (busy),
        .i_cmd                 (i_cmd),
        .i_region_span         (i_region_span),
        .i_reserve_ok          (i_reserve_ok),
        .i_increment           (i_increment),
        .i_policy_allows       (i_policy_allows),
        .o_valid               (o_valid),
        .o_status              (o_status),
        .o_break_offset        (o_break_offset),
        .o_decommit_valid      (o_decommit_valid),
        .o_decommit_start      (o_decommit_start),
        .o_decommit_length     (o_decommit_length),
        .o_heap_page_count     (o_heap_page_count),
        .o_metadata_page_count (o_metadata_page_count),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_data            (i_cfg_data),
        .mismatch_count        (mismatch_count),
        .results_pending       (results_pending)
    );

    // watchdog: too long without any beat ends the run
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready)) begin
            stalled_cycles <= 0;
        end else if (stalled_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    // one command beat, optionally after random idle cycles; start stays high on return
    task automatic send_command(input logic cmd, input logic [SPAN_W-1:0] span,
                                input logic ok, input logic [SPAN_W-1:0] inc,
                                input logic allows, input bit allow_idle);
        if (allow_idle) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
        start           <= 1'b1;
        i_cmd           <= cmd;
        i_region_span   <= span;
        i_reserve_ok    <= ok;
        i_increment     <= inc;
        i_policy_allows <= allows;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
    endtask

    // drain all replies, then write the policy bit
    task automatic write_policy(input logic value);
        start <= 1'b0;
        @(posedge i_clk);
        while (results_pending != 0) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // span whose page count makes the solver swing between two layouts forever
    function automatic logic [SPAN_W-1:0] swinging_span();
        int unsigned m;
        m = $urandom_range(1, 113);
        return SPAN_W'(((1027 * m + 1) << PAGE_SHIFT) | $urandom_range(0, PAGE_BYTES - 1));
    endfunction

    // break change: log-spread growth and shrink, raw words and corner values
    function automatic logic [SPAN_W-1:0] pick_increment();
        int unsigned       kind;
        logic [SPAN_W-1:0] mag;
        kind = $urandom_range(0, 19);
        mag  = $urandom >> $urandom_range(1, 31);
        if (kind < 9) begin
            return mag;
        end else if (kind < 16) begin
            return ~mag;
        end else if (kind < 18) begin
            return $urandom;
        end
        case ($urandom_range(0, 5))
            0:       return 32'h0000_0000;
            1:       return 32'h0000_0001;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            4:       return 32'hFFFF_FFFF;
            default: return 32'h0000_0008;
        endcase
    endfunction

    // before the layout exists: only failing inits and refused adjusts
    task automatic send_early_command();
        case ($urandom_range(0, 3))
            0: send_command(CMD_ADJUST, $urandom, 1'($urandom_range(0, 1)), pick_increment(),
                            1'($urandom_range(0, 1)), 1'b1);
            1: send_command(CMD_INIT, $urandom, 1'b0, $urandom, 1'($urandom_range(0, 1)),
                            1'b1);
            2: send_command(CMD_INIT, $urandom_range(0, 2 * PAGE_BYTES - 1), 1'b1, $urandom,
                            1'($urandom_range(0, 1)), 1'b1);
            default: send_command(CMD_INIT, swinging_span(), 1'b1, $urandom,
                                  1'($urandom_range(0, 1)), 1'b1);
        endcase
    endtask

    task automatic send_random_command(input bit allow_idle);
        if ($urandom_range(0, 99) < 4) begin
            send_command(CMD_INIT, $urandom, 1'($urandom_range(0, 1)), $urandom,
                         1'($urandom_range(0, 1)), allow_idle);
        end else begin
            send_command(CMD_ADJUST, $urandom, 1'($urandom_range(0, 1)), pick_increment(),
                         $urandom_range(0, 3) != 0, allow_idle);
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        i_cmd           <= CMD_INIT;
        i_region_span   <= '0;
        i_reserve_ok    <= 1'b0;
        i_increment     <= '0;
        i_policy_allows <= 1'b0;
        i_cfg_valid     <= 1'b0;
        i_cfg_data      <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_policy(1'b1);

        // no layout yet
        send_command(CMD_ADJUST, 32'h0, 1'b1, 32'h0000_0008, 1'b1, 1'b1);
        send_command(CMD_ADJUST, 32'h0, 1'b1, 32'hFFFF_FFF8, 1'b1, 1'b1);
        send_command(CMD_ADJUST, 32'h0, 1'b1, 32'h0000_0000, 1'b0, 1'b1);
        send_command(CMD_INIT, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b1, 1'b1);
        send_command(CMD_INIT, 32'h0000_0000, 1'b1, 32'h0, 1'b1, 1'b1);
        send_command(CMD_INIT, 32'h0000_0FFF, 1'b1, 32'h0, 1'b1, 1'b1);
        send_command(CMD_INIT, 32'h0000_1000, 1'b1, 32'h0, 1'b1, 1'b1);
        send_command(CMD_INIT, 32'h0000_1FFF, 1'b1, 32'h0, 1'b1, 1'b1);
        send_command(CMD_INIT, 32'd1028 << PAGE_SHIFT, 1'b1, 32'h0, 1'b1, 1'b1);
        repeat (EARLY_ITEMS) send_early_command();

        // the one layout that sticks: whole address space or 2 to 64 pages
        if ($urandom_range(0, 1) != 0) begin
            layout_span = 32'hFFFF_FFFF;
        end else begin
            layout_span = $urandom_range(2 * PAGE_BYTES, 64 * PAGE_BYTES);
        end
        send_command(CMD_INIT, layout_span, 1'b1, $urandom, 1'b1, 1'b1);

        // corners of growth, shrink, policy and repeated init
        send_command(CMD_ADJUST, 32'h0, 1'b1, 32'hFFFF_FFF8, 1'b1, 1'b1);
        send_command(CMD_ADJUST, 32'h0, 1'b1, 32'h0000_0000, 1'b0, 1'b1);
        send_command(CMD_ADJUST, 32'h0, 1'b1, 32'h0000_0000, 1'b1, 1'b1);
        send_command(CMD_ADJUST, 32'h0, 1'b1, 32'h0000_0001, 1'b1, 1'b1);
        send_command(CMD_ADJUST, 32'h0, 1'b1, 32'h0000_0FFF, 1'b1, 1'b1);
        send_command(CMD_ADJUST, 32'h0, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1);
        send_command(CMD_ADJUST, 32'h0, 1'b1, 32'hFFFF_F000, 1'b1, 1'b1);
        send_command(CMD_ADJUST, 32'h0, 1'b1, 32'h7FFF_FFFF, 1'b1, 1'b1);
        send_command(CMD_ADJUST, 32'h0, 1'b1, 32'h8000_0000, 1'b1, 1'b1);
        send_command(CMD_ADJUST, 32'h0, 1'b1, 32'h0000_0007, 1'b0, 1'b1);
        send_command(CMD_INIT, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b1, 1'b1);
        send_command(CMD_INIT, 32'h0000_0000, 1'b0, 32'h0, 1'b1, 1'b1);
        send_command(CMD_ADJUST, 32'h0, 1'b1, 32'h8000_0000, 1'b1, 1'b1);

        // random phases with the policy bit toggled; one long back-to-back stretch
        for (int phase = 0; phase < PHASES; phase++) begin
            write_policy(phase[0]);
            for (int n = 0; n < ITEMS / PHASES; n++) begin
                send_random_command(!(phase == 2 && n < 150));
            end
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (results_pending != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
